// ===== hdl/srehit_pkg.sv =====
// Shared types and constants for the segment/rectangle edge hit block.
// Depends on nothing; used by srehit_ctrl, srehit_dp and segment_rect_edge_hit.
package srehit_pkg;

  localparam int DistBits = 25;
  localparam logic [DistBits-1:0] DIST_MAX = '1;
  localparam int NormBits = 16;

  localparam logic [1:0] EDGE_BOTTOM = 2'd0;
  localparam logic [1:0] EDGE_RIGHT  = 2'd1;
  localparam logic [1:0] EDGE_TOP    = 2'd2;
  localparam logic [1:0] EDGE_LEFT   = 2'd3;

  // Product selects of the shared multiplier, issued in this order per edge.
  typedef enum logic [2:0] {
    MOP_P,
    MOP_LO,
    MOP_HI,
    MOP_MIN,
    MOP_MAX,
    MOP_NUM
  } mop_e;

  typedef struct packed {
    logic       load;
    logic       edge_init;
    logic       mul_en;
    mop_e       mul_sel;
    logic       div_init;
    logic       div_step;
    logic       commit;
    logic       out_load;
    logic [1:0] edge_sel;
  } cmd_t;

  typedef struct packed {
    logic pre_ok;
    logic hit_ok;
  } status_t;

endpackage

// ===== hdl/srehit_ctrl.sv =====
// Sequencer for the edge hit block: walks the bottom, right, top and left edges, multiplies, divides.
// Depends on srehit_pkg; drives srehit_dp through cmd_t and reads status_t.
module srehit_ctrl #(
  parameter int DivSteps = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  srehit_pkg::status_t status_i,
  output srehit_pkg::cmd_t    cmd_o
);

  localparam int CntW = $clog2(DivSteps + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK, ST_MUL, ST_DRAIN, ST_DECIDE, ST_DIVI, ST_DIVS, ST_FIN, ST_DONE
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      edge_q;
  logic            out_valid_q;
  logic            out_free;
  logic            last_edge;

  assign out_free    = !out_valid_q || out_ready_i;
  assign last_edge   = (edge_q == srehit_pkg::EDGE_LEFT);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = srehit_pkg::MOP_P;
    cmd_o.edge_sel = edge_q;
    case (state_q)
      ST_IDLE:  cmd_o.load = in_valid_i;
      ST_CHK:   cmd_o.edge_init = 1'b1;
      ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = srehit_pkg::mop_e'(cnt_q[2:0]);
      end
      ST_DIVI:  cmd_o.div_init = 1'b1;
      ST_DIVS:  cmd_o.div_step = 1'b1;
      ST_FIN:   cmd_o.commit = 1'b1;
      ST_DONE:  cmd_o.out_load = out_free;
      default:  cmd_o.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      edge_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result sets valid; an accepted result clears it.
      out_valid_q <= ((state_q == ST_DONE) && out_free) || (out_valid_q && !out_ready_i);
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            edge_q  <= srehit_pkg::EDGE_BOTTOM;
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          cnt_q <= '0;
          if (status_i.pre_ok) begin
            state_q <= ST_MUL;
          end else if (last_edge) begin
            state_q <= ST_DONE;
          end else begin
            edge_q <= edge_q + 2'd1;
          end
        end
        ST_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (srehit_pkg::mop_e'(cnt_q[2:0]) == srehit_pkg::MOP_NUM) state_q <= ST_DRAIN;
        end
        ST_DRAIN: state_q <= ST_DECIDE;
        ST_DECIDE: begin
          if (status_i.hit_ok) begin
            state_q <= ST_DIVI;
          end else if (last_edge) begin
            state_q <= ST_DONE;
          end else begin
            edge_q  <= edge_q + 2'd1;
            state_q <= ST_CHK;
          end
        end
        ST_DIVI: begin
          cnt_q   <= '0;
          state_q <= ST_DIVS;
        end
        ST_DIVS: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DivSteps - 1)) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (last_edge) begin
            state_q <= ST_DONE;
          end else begin
            edge_q  <= edge_q + 2'd1;
            state_q <= ST_CHK;
          end
        end
        ST_DONE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/srehit_dp.sv =====
// Datapath of the edge hit block: edge setup, shared multiplier, bound checks,
// restoring divider, distance and the output register. Depends on srehit_pkg.
module srehit_dp #(
  parameter int CoordBits = 16,
  parameter int FracBits  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [CoordBits-1:0]   rect_x_i,
  input  logic signed [CoordBits-1:0]   rect_y_i,
  input  logic        [CoordBits-2:0]   rect_w_i,
  input  logic        [CoordBits-2:0]   rect_h_i,
  input  logic signed [CoordBits-1:0]   seg_x0_i,
  input  logic signed [CoordBits-1:0]   seg_y0_i,
  input  logic signed [CoordBits-1:0]   seg_x1_i,
  input  logic signed [CoordBits-1:0]   seg_y1_i,
  input  srehit_pkg::cmd_t              cmd_i,
  output srehit_pkg::status_t           status_o,
  output logic                          hit_o,
  output logic        [1:0]             hit_edge_o,
  output logic signed [srehit_pkg::NormBits-1:0] normal_x_o,
  output logic signed [srehit_pkg::NormBits-1:0] normal_y_o,
  output logic        [srehit_pkg::DistBits-1:0] hit_distance_o
);

  localparam int EW  = CoordBits + 2;
  localparam int PW  = 2 * EW;
  localparam int XW  = PW + 1;
  localparam int QW  = CoordBits + FracBits + 1;
  localparam int RW  = CoordBits + 2;
  localparam int NW  = XW + FracBits;
  localparam int DW  = CoordBits + FracBits + 4;
  localparam int SW  = (DW > srehit_pkg::DistBits + 1) ? DW : srehit_pkg::DistBits + 1;
  localparam int NB  = srehit_pkg::NormBits;

  logic signed [CoordBits-1:0] rx_q, ry_q, x0_q, y0_q, x1_q, y1_q;
  logic        [CoordBits-2:0] w_q, h_q;

  logic signed [EW-1:0] rxe, rye, we, he, x0e, y0e, x1e, y1e;
  logic signed [EW-1:0] c, lo, len, hi, a0, a1, b0, b1;
  logic signed [EW-1:0] den, t, u, db, bmin, bmax, ma, mb;
  logic                 den_neg;
  logic        [EW-1:0] dmag;

  logic signed [PW-1:0] prod_q, p_q;
  srehit_pkg::mop_e     tag_q;
  logic                 pv_q, ok_q, num_neg_q;
  logic signed [XW-1:0] e_val;
  logic        [XW-1:0] nmag_q;

  logic [NW-1:0] nd;
  logic [RW-1:0] r_q, trial, dmag_r;
  logic [QW-1:0] q_q;
  logic          q_ge;

  logic signed [QW:0]   bs;
  logic signed [DW-1:0] d1s, d2s;
  logic        [DW-1:0] d1, d2;
  logic        [SW-1:0] dsum;
  logic [srehit_pkg::DistBits-1:0] dsat;

  logic signed [NB-1:0] wn, hn;

  logic                 any_q;
  logic [1:0]           edge_q;
  logic signed [NB-1:0] nx_q, ny_q;
  logic [srehit_pkg::DistBits-1:0] held_q;

  assign rxe = EW'(rx_q);
  assign rye = EW'(ry_q);
  assign we  = EW'({1'b0, w_q});
  assign he  = EW'({1'b0, h_q});
  assign x0e = EW'(x0_q);
  assign y0e = EW'(y0_q);
  assign x1e = EW'(x1_q);
  assign y1e = EW'(y1_q);

  // Bottom and top edges are horizontal lines y = c spanning x; right and left
  // edges are vertical lines x = c spanning y.
  always_comb begin
    case (cmd_i.edge_sel)
      srehit_pkg::EDGE_BOTTOM: begin
        c = rye; lo = rxe; len = we; a0 = y0e; a1 = y1e; b0 = x0e; b1 = x1e;
      end
      srehit_pkg::EDGE_RIGHT: begin
        c = rxe + we; lo = rye; len = he; a0 = x0e; a1 = x1e; b0 = y0e; b1 = y1e;
      end
      srehit_pkg::EDGE_TOP: begin
        c = rye + he; lo = rxe; len = we; a0 = y0e; a1 = y1e; b0 = x0e; b1 = x1e;
      end
      default: begin
        c = rxe; lo = rye; len = he; a0 = x0e; a1 = x1e; b0 = y0e; b1 = y1e;
      end
    endcase
  end

  assign hi      = lo + len;
  assign den     = a1 - a0;
  assign t       = c - a0;
  assign u       = c - a1;
  assign db      = b1 - b0;
  assign bmin    = (b0 < b1) ? b0 : b1;
  assign bmax    = (b0 > b1) ? b0 : b1;
  assign den_neg = den[EW-1];
  assign dmag    = den_neg ? EW'(-den) : EW'(den);

  assign status_o.pre_ok = (len != '0) && (den != '0) &&
                           (((t >= 0) && (u <= 0)) || ((t <= 0) && (u >= 0)));
  assign status_o.hit_ok = ok_q;

  // Every bound test is the sign of (b0 - v) * den + P, with P = t * db.
  always_comb begin
    case (cmd_i.mul_sel)
      srehit_pkg::MOP_P:   begin ma = t;         mb = db;  end
      srehit_pkg::MOP_LO:  begin ma = b0 - lo;   mb = den; end
      srehit_pkg::MOP_HI:  begin ma = b0 - hi;   mb = den; end
      srehit_pkg::MOP_MIN: begin ma = b0 - bmin; mb = den; end
      srehit_pkg::MOP_MAX: begin ma = b0 - bmax; mb = den; end
      default:             begin ma = b0;        mb = den; end
    endcase
  end

  assign e_val = XW'(prod_q) + XW'(p_q);

  assign nd     = NW'(nmag_q) << FracBits;
  assign trial  = {r_q[RW-2:0], q_q[QW-1]};
  assign dmag_r = RW'(dmag);
  assign q_ge   = (trial >= dmag_r);

  assign bs   = num_neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
  assign d1s  = DW'(bs) - (DW'(b0) <<< FracBits);
  assign d2s  = DW'(t) <<< FracBits;
  assign d1   = d1s[DW-1] ? DW'(-d1s) : DW'(d1s);
  assign d2   = d2s[DW-1] ? DW'(-d2s) : DW'(d2s);
  assign dsum = SW'(d1) + SW'(d2);
  assign dsat = (dsum > SW'(srehit_pkg::DIST_MAX)) ? srehit_pkg::DIST_MAX
                                                   : dsum[srehit_pkg::DistBits-1:0];

  assign wn = NB'({1'b0, w_q});
  assign hn = NB'({1'b0, h_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      held_q <= '0;
    end else begin
      pv_q <= cmd_i.mul_en;
      if (cmd_i.commit) held_q <= dsat;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    tag_q  <= cmd_i.mul_sel;
    if (cmd_i.load) begin
      rx_q   <= rect_x_i;
      ry_q   <= rect_y_i;
      w_q    <= rect_w_i;
      h_q    <= rect_h_i;
      x0_q   <= seg_x0_i;
      y0_q   <= seg_y0_i;
      x1_q   <= seg_x1_i;
      y1_q   <= seg_y1_i;
      any_q  <= 1'b0;
      edge_q <= srehit_pkg::EDGE_BOTTOM;
      nx_q   <= '0;
      ny_q   <= '0;
    end
    if (cmd_i.edge_init) ok_q <= 1'b1;
    if (pv_q) begin
      case (tag_q)
        srehit_pkg::MOP_P: p_q <= prod_q;
        srehit_pkg::MOP_LO, srehit_pkg::MOP_MIN: begin
          if (!((e_val == '0) || (e_val[XW-1] == den_neg))) ok_q <= 1'b0;
        end
        srehit_pkg::MOP_HI, srehit_pkg::MOP_MAX: begin
          if (!((e_val == '0) || (e_val[XW-1] != den_neg))) ok_q <= 1'b0;
        end
        default: begin
          num_neg_q <= (e_val != '0) && (e_val[XW-1] != den_neg);
          nmag_q    <= e_val[XW-1] ? XW'(-e_val) : XW'(e_val);
        end
      endcase
    end
    if (cmd_i.div_init) begin
      r_q <= RW'(nd >> QW);
      q_q <= nd[QW-1:0];
    end
    if (cmd_i.div_step) begin
      r_q <= q_ge ? (trial - dmag_r) : trial;
      q_q <= {q_q[QW-2:0], q_ge};
    end
    if (cmd_i.commit) begin
      any_q  <= 1'b1;
      edge_q <= cmd_i.edge_sel;
      case (cmd_i.edge_sel)
        srehit_pkg::EDGE_BOTTOM: begin nx_q <= '0;  ny_q <= -wn; end
        srehit_pkg::EDGE_RIGHT:  begin nx_q <= -hn; ny_q <= '0;  end
        srehit_pkg::EDGE_TOP:    begin nx_q <= '0;  ny_q <= wn;  end
        default:                 begin nx_q <= hn;  ny_q <= '0;  end
      endcase
    end
    if (cmd_i.out_load) begin
      hit_o          <= any_q;
      hit_edge_o     <= edge_q;
      normal_x_o     <= nx_q;
      normal_y_o     <= ny_q;
      hit_distance_o <= held_q;
    end
  end

endmodule

// ===== hdl/segment_rect_edge_hit.sv =====
// Top level of the segment/rectangle edge hit block.
// Depends on srehit_pkg, srehit_ctrl and srehit_dp.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid_i/in_ready_o  | rect_x/y, rect_w/h, seg_x0/y0, seg_x1/y1
//   out     | out_valid_o/out_ready_i| hit, hit_edge, normal_x/y, hit_distance
//
// One transaction is worked at a time. An edge rejected by its early tests
// (zero length, parallel, line outside the segment span) ends at its check; a
// tested edge runs check, six multiplier products, drain and decide, and a
// hit adds divider setup, COORD_BITS+FRAC_BITS+1 divider steps and commit.
// The divider yields one quotient bit per cycle.
// Reset clears the control state and the held distance to zero. The result
// sits in an output register, so a new input transaction is taken while the
// previous result still waits; a stalled output only delays the next handoff.
module segment_rect_edge_hit #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_BITS-1:0]  rect_x_i,
  input  logic signed [COORD_BITS-1:0]  rect_y_i,
  input  logic        [COORD_BITS-2:0]  rect_w_i,
  input  logic        [COORD_BITS-2:0]  rect_h_i,
  input  logic signed [COORD_BITS-1:0]  seg_x0_i,
  input  logic signed [COORD_BITS-1:0]  seg_y0_i,
  input  logic signed [COORD_BITS-1:0]  seg_x1_i,
  input  logic signed [COORD_BITS-1:0]  seg_y1_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic        [1:0]             hit_edge_o,
  output logic signed [15:0]            normal_x_o,
  output logic signed [15:0]            normal_y_o,
  output logic        [24:0]            hit_distance_o
);

  // The quotient of the hit coordinate needs this many restoring steps.
  localparam int DivSteps = COORD_BITS + FRAC_BITS + 1;

  srehit_pkg::cmd_t    cmd;
  srehit_pkg::status_t status;

  // The controller sequences edges and units; it never touches payload.
  srehit_ctrl #(
    .DivSteps (DivSteps)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the item, the multiplier, the divider and the results.
  srehit_dp #(
    .CoordBits (COORD_BITS),
    .FracBits  (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rect_x_i       (rect_x_i),
    .rect_y_i       (rect_y_i),
    .rect_w_i       (rect_w_i),
    .rect_h_i       (rect_h_i),
    .seg_x0_i       (seg_x0_i),
    .seg_y0_i       (seg_y0_i),
    .seg_x1_i       (seg_x1_i),
    .seg_y1_i       (seg_y1_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .hit_o          (hit_o),
    .hit_edge_o     (hit_edge_o),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .hit_distance_o (hit_distance_o)
  );

  // Only one transaction is in flight, so ready drops right after acceptance.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while another transaction is in flight");

  // A miss reports edge zero and a zero normal.
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |->
      (hit_edge_o == srehit_pkg::EDGE_BOTTOM && normal_x_o == '0 && normal_y_o == '0))
    else $error("miss result carries edge or normal data");

  // Horizontal edges have a normal along y only.
  a_horiz_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o &&
     (hit_edge_o == srehit_pkg::EDGE_BOTTOM || hit_edge_o == srehit_pkg::EDGE_TOP))
      |-> (normal_x_o == '0))
    else $error("horizontal edge hit with nonzero normal x");

endmodule
